// ===== hdl/lbcd_pkg.sv =====
// Shared types and constants for the LRU block cache directory.
package lbcd_pkg;
	localparam int Capacity = 32;
	localparam int SlotW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);
	localparam int ThrW = 6;
	localparam int TagW = 32;
	localparam logic [ThrW-1:0] ThrReset = 6'd24;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT    = 3'd0,
		ST_MISS   = 3'd1,
		ST_BUSY   = 3'd2,
		ST_FULL   = 3'd3,
		ST_ABSENT = 3'd4
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch request, compare tags
		logic promote;   // hit acquire: move to MRU, mark acquired
		logic release_m; // clear acquired
		logic pin_set;
		logic pin_clr;
		logic walk_step; // examine rank walk_pos-1
		logic insert;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic hit_acq;
		logic walk_go;   // walk should continue
		logic can_insert;
	} dp_sts_t;
endpackage

// ===== hdl/lru_block_cache_directory_core.sv =====
// Top level of the LRU block cache directory.
// Channel   | Dir | Group                 | Contents
// request   | in  | s_tvalid/tready/tdata | operation, block_number
// result    | out | m_tvalid/tready/tdata | status, evicted_count, cached_count
// threshold | in  | cfg_we/cfg_wdata      | LRU eviction level
// One request at a time: accept, decode/tag compare, then for an
// acquire miss an eviction walk of one recency rank per cycle (up to
// entry_count ranks, while entry_count is at least the threshold, then
// a step that ends the walk) and an insert step, then the result register.
// Result register parts the sides; the next request is taken once the
// result is loaded. Reset: empty directory, threshold 24.
module lru_block_cache_directory_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [1:0] operation, [33:2] block_number, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [2:0] status, [8:3] evicted_count, [14:9] cached_count
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata
);
	logic [lbcd_pkg::ThrW-1:0] thr_q;
	lbcd_pkg::dp_cmd_t cmd;
	lbcd_pkg::dp_sts_t sts;
	logic [lbcd_pkg::CountW-1:0] count, evicted;
	logic in_fire, out_free, res_load;
	logic [2:0] res_status;
	logic [14:0] res_q;
	logic vld_q;

	assign in_fire = s_tvalid && s_tready;
	assign out_free = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= lbcd_pkg::ThrReset;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	lbcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .op_in(s_tdata[1:0]),
		.out_free(out_free), .in_ready(s_tready), .res_load(res_load),
		.res_status(res_status), .cmd(cmd), .sts(sts)
	);

	lbcd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .thr(thr_q),
		.blk_in(s_tdata[33:2]), .cmd(cmd), .sts(sts), .count(count), .evicted(evicted)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (res_load) vld_q <= 1'b1;
		else if (m_tready) vld_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) res_q <= {6'(count), 6'(evicted), res_status};
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {1'b0, res_q};

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!vld_q || m_tready)) else $error("result overwritten");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> res_q[2:0] <= 3'd4) else $error("bad status code");
	a_evict_only_miss: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && res_q[8:3] != 6'd0 |-> (res_q[2:0] == 3'd1 || res_q[2:0] == 3'd3))
		else $error("eviction on non-miss");
`endif
endmodule

// ===== hdl/lbcd_datapath.sv =====
// Directory datapath: tags, marks, recency ranks, counters.
module lbcd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lbcd_pkg::ThrW-1:0]        thr,
	input  logic [lbcd_pkg::TagW-1:0]        blk_in,
	input  lbcd_pkg::dp_cmd_t                cmd,
	output lbcd_pkg::dp_sts_t                sts,
	output logic [lbcd_pkg::CountW-1:0]      count,
	output logic [lbcd_pkg::CountW-1:0]      evicted
);
	localparam int N = lbcd_pkg::Capacity;
	localparam int SW = lbcd_pkg::SlotW;
	localparam int CW = lbcd_pkg::CountW;

	logic [lbcd_pkg::TagW-1:0] tag_q [N];
	logic [SW-1:0] rank_q [N];
	logic [N-1:0] valid_q, acq_q, pin_q;
	logic [CW-1:0] count_q, evict_q, pos_q;
	logic [lbcd_pkg::TagW-1:0] blk_q;
	logic hit_q;
	logic [SW-1:0] hslot_q;

	logic [N-1:0] match;
	logic [SW-1:0] mslot, free_slot, vslot;
	logic any_free, vfound;
	logic [SW-1:0] want_rank;
	logic [CW:0] cnt_ext;
	logic [CW:0] thr_ext;

	assign want_rank = SW'(pos_q - CW'(1));
	assign cnt_ext = {1'b0, count_q};
	assign thr_ext = (CW+1)'(thr);

	always_comb begin
		match = '0;
		mslot = '0;
		free_slot = '0;
		any_free = 1'b0;
		vslot = '0;
		vfound = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tag_q[i] == blk_in);
			if (match[i]) mslot = SW'(i);
			if (!valid_q[i]) begin
				free_slot = SW'(i);
				any_free = 1'b1;
			end
			if (valid_q[i] && rank_q[i] == want_rank) begin
				vslot = SW'(i);
				vfound = 1'b1;
			end
		end
	end

	assign sts.hit = hit_q;
	assign sts.hit_acq = acq_q[hslot_q];
	assign sts.walk_go = (pos_q != '0) && (cnt_ext >= thr_ext);
	assign sts.can_insert = any_free && (count_q < CW'(N));
	assign count = count_q;
	assign evicted = evict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			acq_q <= '0;
			pin_q <= '0;
			count_q <= '0;
			evict_q <= '0;
			pos_q <= '0;
			hit_q <= 1'b0;
			hslot_q <= '0;
		end else begin
			if (cmd.load) begin
				hit_q <= |match;
				hslot_q <= mslot;
				blk_q <= blk_in;
				evict_q <= '0;
				pos_q <= count_q;
			end
			if (cmd.promote) begin
				for (int i = 0; i < N; i++)
					if (valid_q[i] && rank_q[i] < rank_q[hslot_q]) rank_q[i] <= rank_q[i] + SW'(1);
				rank_q[hslot_q] <= '0;
				acq_q[hslot_q] <= 1'b1;
			end
			if (cmd.release_m) acq_q[hslot_q] <= 1'b0;
			if (cmd.pin_set) pin_q[hslot_q] <= 1'b1;
			if (cmd.pin_clr) pin_q[hslot_q] <= 1'b0;
			if (cmd.walk_step) begin
				pos_q <= pos_q - CW'(1);
				if (vfound && !pin_q[vslot] && !acq_q[vslot]) begin
					valid_q[vslot] <= 1'b0;
					acq_q[vslot] <= 1'b0;
					pin_q[vslot] <= 1'b0;
					for (int i = 0; i < N; i++)
						if (valid_q[i] && rank_q[i] > want_rank) rank_q[i] <= rank_q[i] - SW'(1);
					count_q <= count_q - CW'(1);
					evict_q <= evict_q + CW'(1);
				end
			end
			if (cmd.insert) begin
				for (int i = 0; i < N; i++)
					if (valid_q[i]) rank_q[i] <= rank_q[i] + SW'(1);
				tag_q[free_slot] <= blk_q;
				valid_q[free_slot] <= 1'b1;
				acq_q[free_slot] <= 1'b1;
				pin_q[free_slot] <= 1'b0;
				rank_q[free_slot] <= '0;
				count_q <= count_q + CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N)) else $error("count over capacity");
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q)) else $error("count mismatch");
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> any_free) else $error("insert with no free slot");
`endif
endmodule

// ===== hdl/lbcd_ctrl.sv =====
// Controller state machine sequencing one request at a time.
module lbcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [1:0]        op_in,
	input  logic              out_free,
	output logic              in_ready,
	output logic              res_load,
	output logic [2:0]        res_status,
	output lbcd_pkg::dp_cmd_t cmd,
	input  lbcd_pkg::dp_sts_t sts
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_WALK = 5'b00100,
		S_INS  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic [2:0] stat_q, stat_d;

	assign in_ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_OUT) && out_free;
	assign res_status = stat_q;

	always_comb begin
		state_d = state_q;
		stat_d = stat_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (op_q == lbcd_pkg::OP_ACQUIRE) begin
					if (sts.hit) begin
						if (sts.hit_acq) stat_d = lbcd_pkg::ST_BUSY;
						else begin
							cmd.promote = 1'b1;
							stat_d = lbcd_pkg::ST_HIT;
						end
						state_d = S_OUT;
					end else state_d = S_WALK;
				end else if (!sts.hit) begin
					stat_d = lbcd_pkg::ST_ABSENT;
					state_d = S_OUT;
				end else begin
					stat_d = lbcd_pkg::ST_HIT;
					cmd.release_m = (op_q == lbcd_pkg::OP_RELEASE);
					cmd.pin_set = (op_q == lbcd_pkg::OP_PIN);
					cmd.pin_clr = (op_q == lbcd_pkg::OP_UNPIN);
					state_d = S_OUT;
				end
			end
			S_WALK: begin
				if (sts.walk_go) cmd.walk_step = 1'b1;
				else state_d = S_INS;
			end
			S_INS: begin
				if (sts.can_insert) begin
					cmd.insert = 1'b1;
					stat_d = lbcd_pkg::ST_MISS;
				end else stat_d = lbcd_pkg::ST_FULL;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			stat_q <= '0;
		end else begin
			state_q <= state_d;
			stat_q <= stat_d;
			if (in_fire) op_q <= op_in;
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_DEC) else $error("accept did not start decode");
	a_walk_only_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> state_q == S_WALK) else $error("walk step outside walk");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("several commands at once");
`endif
endmodule
